// ===== sv/sgsm_pkg.sv =====
// Shared types and constants for the edge-clamped smoothing filter.
// Used by sgsm_ctrl, sgsm_dp and savgol_edge_clamped_smoother_core.
package sgsm_pkg;

    // Sample and weight formats
    localparam int SAMPLE_BITS   = 16;
    localparam int WEIGHT_BITS   = 18;
    localparam int FRAC_BITS     = 16;
    localparam int NUM_WREGS     = 5;
    localparam int WH_BITS       = 3;
    localparam int MAX_HALF_DEF  = 4;
    localparam int ROUND_HALF    = 32768;
    localparam int SMP_MAX       = (2 ** (SAMPLE_BITS - 1)) - 1;
    localparam int SMP_MIN       = -(2 ** (SAMPLE_BITS - 1));

    // Configuration port
    localparam int CFG_IDX_BITS  = 3;
    localparam int CFG_DATA_BITS = 18;

    typedef logic [CFG_IDX_BITS-1:0] t_cfg_idx;

    localparam t_cfg_idx CFG_WINDOW_HALF   = 3'd0;
    localparam t_cfg_idx CFG_WEIGHT_CENTER = 3'd1;
    localparam t_cfg_idx CFG_WEIGHT_OFF4   = 3'd5;

    typedef logic signed [WEIGHT_BITS-1:0] t_weight;

    localparam t_weight WEIGHT_CENTER_RST = 18'sd65536;

    // Input transaction
    typedef struct packed {
        logic signed [SAMPLE_BITS-1:0] sample;
        logic                          final_sample;
    } t_in_item;

    // Output transaction
    typedef struct packed {
        logic signed [SAMPLE_BITS-1:0] smoothed;
        logic                          clipped;
        logic                          end_of_run;
    } t_out_item;

    // Commands from the controller to the datapath
    typedef struct packed {
        logic shift;       // take the accepted sample into the window
        logic clr;         // clear the accumulator
        logic mac;         // multiply the selected tap
        logic load_out;    // round, saturate and load the output register
        logic end_flag;    // mark the loaded result as end of run
        logic clear_seen;  // start a new sequence
    } t_dp_cmd;

endpackage

// ===== sv/sgsm_dp.sv =====
// Datapath of the smoothing filter: config registers, sample window,
// shared multiply-accumulate unit, rounding and the output register. Uses sgsm_pkg.
module sgsm_dp
    import sgsm_pkg::*;
#(
    parameter int MAX_HALF = MAX_HALF_DEF,
    localparam int WIN   = 2 * MAX_HALF + 1,
    localparam int K_W   = $clog2(WIN),
    localparam int D_W   = $clog2(MAX_HALF + 1),
    localparam int CNT_W = $clog2(WIN + 1)
) (
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  logic                     i_cfg_valid,
    input  t_cfg_idx                 i_cfg_index,
    input  logic [CFG_DATA_BITS-1:0] i_cfg_data,
    input  logic signed [SAMPLE_BITS-1:0] i_sample,
    input  t_dp_cmd                  i_cmd,
    input  logic [D_W-1:0]           i_d,
    input  logic [K_W-1:0]           i_k,
    input  logic                     i_out_stall,
    output logic [CNT_W-1:0]         o_seen,
    output logic [D_W-1:0]           o_h,
    output logic                     o_busy,
    output logic                     o_out_valid,
    output t_out_item                o_out_data
);

    localparam int PROD_W = WEIGHT_BITS + SAMPLE_BITS;
    localparam int ACC_W  = PROD_W + $clog2(WIN);

    logic [WH_BITS-1:0]            r_wh;
    t_weight                       r_wt [NUM_WREGS];
    logic signed [SAMPLE_BITS-1:0] r_win [WIN];
    logic signed [SAMPLE_BITS-1:0] r_first;
    logic [CNT_W-1:0]              r_seen;
    logic signed [PROD_W-1:0]      r_prod;
    logic                          r_pvld;
    logic signed [ACC_W-1:0]       r_acc;
    logic                          r_out_valid;
    t_out_item                     r_out;

    logic [D_W-1:0]                h_eff;
    logic [K_W:0]                  dh;
    logic signed [K_W+1:0]         age;
    logic signed [K_W+1:0]         kh;
    logic [K_W:0]                  off;
    logic signed [SAMPLE_BITS-1:0] tap_x;
    t_weight                       tap_w;
    logic signed [ACC_W:0]         rsum;
    logic signed [ACC_W:0]         rq;
    logic signed [SAMPLE_BITS-1:0] sat_val;
    logic                          sat_clip;

    // Write configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wh    <= '0;
            r_wt[0] <= WEIGHT_CENTER_RST;
            for (int i = 1; i < NUM_WREGS; i++) begin
                r_wt[i] <= '0;
            end
        end else if (i_cfg_valid) begin
            if (i_cfg_index == CFG_WINDOW_HALF) begin
                r_wh <= i_cfg_data[WH_BITS-1:0];
            end else if (i_cfg_index >= CFG_WEIGHT_CENTER &&
                         i_cfg_index <= CFG_WEIGHT_OFF4) begin
                r_wt[i_cfg_index - CFG_WEIGHT_CENTER] <= $signed(i_cfg_data);
            end
        end
    end

    // Limit the half window to what the window can hold
    always_comb begin
        if (int'(r_wh) > MAX_HALF) begin
            h_eff = D_W'(MAX_HALF);
        end else begin
            h_eff = D_W'(r_wh);
        end
    end

    // Shift the accepted sample in; keep the first one of the sequence
    always_ff @(posedge i_clk) begin
        if (i_cmd.shift) begin
            for (int i = WIN - 1; i > 0; i--) begin
                r_win[i] <= r_win[i-1];
            end
            r_win[0] <= i_sample;
            if (r_seen == '0) begin
                r_first <= i_sample;
            end
        end
    end

    // Count samples of the sequence, saturating at the window depth
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_seen <= '0;
        end else if (i_cmd.clear_seen) begin
            r_seen <= '0;
        end else if (i_cmd.shift && r_seen != CNT_W'(WIN)) begin
            r_seen <= r_seen + 1'b1;
        end
    end

    // Select tap k of the output centered at age d, with edge clamping
    always_comb begin
        dh  = (K_W+1)'(i_d) + (K_W+1)'(h_eff);
        age = $signed({1'b0, dh}) - $signed({2'b00, i_k});
        kh  = $signed({2'b00, i_k}) - $signed((K_W+2)'(h_eff));
        if (kh[K_W+1]) begin
            off = (K_W+1)'(-kh);
        end else begin
            off = kh[K_W:0];
        end
        if (age[K_W+1]) begin
            tap_x = r_win[0];
        end else if (int'(age[K_W:0]) >= int'(r_seen)) begin
            tap_x = r_first;
        end else begin
            tap_x = r_win[age[K_W-1:0]];
        end
        tap_w = '0;
        for (int i = 0; i < NUM_WREGS; i++) begin
            if (int'(off) == i) begin
                tap_w = r_wt[i];
            end
        end
    end

    // Multiply one tap, then accumulate the registered product
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pvld <= 1'b0;
        end else begin
            r_pvld <= i_cmd.mac;
        end
    end

    always_ff @(posedge i_clk) begin
        r_prod <= tap_w * tap_x;
        if (i_cmd.clr) begin
            r_acc <= '0;
        end else if (r_pvld) begin
            r_acc <= r_acc + ACC_W'(r_prod);
        end
    end

    // Round half up, drop the fraction and saturate
    always_comb begin
        rsum     = (ACC_W+1)'(r_acc) + (ACC_W+1)'(ROUND_HALF);
        rq       = rsum >>> FRAC_BITS;
        sat_clip = 1'b0;
        if (rq > $signed((ACC_W+1)'(SMP_MAX))) begin
            sat_val  = SAMPLE_BITS'(SMP_MAX);
            sat_clip = 1'b1;
        end else if (rq < $signed((ACC_W+1)'(SMP_MIN))) begin
            sat_val  = SAMPLE_BITS'(SMP_MIN);
            sat_clip = 1'b1;
        end else begin
            sat_val = rq[SAMPLE_BITS-1:0];
        end
    end

    // Hold the result until the output transaction completes
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_cmd.load_out) begin
            r_out_valid <= 1'b1;
        end else if (!i_out_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load_out) begin
            r_out.smoothed   <= sat_val;
            r_out.clipped    <= sat_clip;
            r_out.end_of_run <= i_cmd.end_flag;
        end
    end

    assign o_seen      = r_seen;
    assign o_h         = h_eff;
    assign o_busy      = r_out_valid && i_out_stall;
    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;

endmodule

// ===== sv/sgsm_ctrl.sv =====
// Controller of the smoothing filter: accepts samples, decides how many
// results each one releases and steps the datapath through the taps. Uses sgsm_pkg.
module sgsm_ctrl
    import sgsm_pkg::*;
#(
    parameter int MAX_HALF = MAX_HALF_DEF,
    localparam int WIN   = 2 * MAX_HALF + 1,
    localparam int K_W   = $clog2(WIN),
    localparam int D_W   = $clog2(MAX_HALF + 1),
    localparam int CNT_W = $clog2(WIN + 1)
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_in_valid,
    input  logic             i_final,
    input  logic [CNT_W-1:0] i_seen,
    input  logic [D_W-1:0]   i_h,
    input  logic             i_busy,
    output logic             o_in_stall,
    output t_dp_cmd          o_cmd,
    output logic [D_W-1:0]   o_d,
    output logic [K_W-1:0]   o_k
);

    typedef enum logic [2:0] {
        S_IDLE,
        S_DECIDE,
        S_MAC,
        S_ACC,
        S_RND
    } t_state;

    t_state         r_state, n_state;
    logic [D_W-1:0] r_d, n_d;
    logic [K_W-1:0] r_k, n_k;
    logic           r_fin, n_fin;
    t_dp_cmd        cmd;
    logic           accept;

    assign accept = i_in_valid && (r_state == S_IDLE);

    // Per sample: accept, decide, run taps, drain and load each result it releases
    always_comb begin
        n_state = r_state;
        n_d     = r_d;
        n_k     = r_k;
        n_fin   = r_fin;
        cmd     = '0;
        case (r_state)
            S_IDLE: begin
                if (accept) begin
                    cmd.shift = 1'b1;
                    n_fin     = i_final;
                    n_state   = S_DECIDE;
                end
            end
            S_DECIDE: begin
                if (r_fin) begin
                    if (int'(i_seen) - 1 < int'(i_h)) begin
                        n_d = D_W'(i_seen - 1'b1);
                    end else begin
                        n_d = i_h;
                    end
                    cmd.clr = 1'b1;
                    n_k     = '0;
                    n_state = S_MAC;
                end else if (int'(i_seen) > int'(i_h)) begin
                    n_d     = i_h;
                    cmd.clr = 1'b1;
                    n_k     = '0;
                    n_state = S_MAC;
                end else begin
                    n_state = S_IDLE;
                end
            end
            S_MAC: begin
                cmd.mac = 1'b1;
                if (int'(r_k) == 2 * int'(i_h)) begin
                    n_state = S_ACC;
                end else begin
                    n_k = r_k + 1'b1;
                end
            end
            S_ACC: begin
                n_state = S_RND;
            end
            S_RND: begin
                if (!i_busy) begin
                    cmd.load_out = 1'b1;
                    cmd.end_flag = r_fin && (r_d == '0);
                    if (r_fin && r_d != '0) begin
                        n_d     = r_d - 1'b1;
                        n_k     = '0;
                        cmd.clr = 1'b1;
                        n_state = S_MAC;
                    end else begin
                        cmd.clear_seen = r_fin;
                        n_state        = S_IDLE;
                    end
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // Hold state and counters
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_d     <= '0;
            r_k     <= '0;
            r_fin   <= 1'b0;
        end else begin
            r_state <= n_state;
            r_d     <= n_d;
            r_k     <= n_k;
            r_fin   <= n_fin;
        end
    end

    assign o_in_stall = (r_state != S_IDLE);
    assign o_cmd      = cmd;
    assign o_d        = r_d;
    assign o_k        = r_k;

    // The tap counter never runs past the window
    a_tap_in_window: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        cmd.mac |-> int'(r_k) <= 2 * int'(i_h))
        else $error("tap counter beyond window");

    // A result is never loaded over one still waiting to be taken
    a_no_overwrite: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        cmd.load_out |-> !i_busy)
        else $error("output register overwritten");

    // The center age stays inside the half window while taps run
    a_center_in_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_MAC || r_state == S_ACC || r_state == S_RND)
            |-> int'(r_d) <= int'(i_h))
        else $error("center age beyond half window");

    // The last result of a sequence ends the sequence
    a_end_clears: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        cmd.end_flag |-> cmd.clear_seen)
        else $error("end of run without sequence restart");

endmodule

// ===== sv/savgol_edge_clamped_smoother_core.sv =====
// Edge-clamped smoothing filter, one shared 18 x 16 multiplier over 2h+1 taps.
// A new sample is accepted only while the controller is idle, so the input stalls until
// each result of the prior sample is loaded; a non-final sample releases one result or
// none, and a final sample releases n <= h+1 results.
// Reset clears control state, sets window_half = 0, weight_center = 1.0 and
// the other weights to zero; the sample window is not cleared.
module savgol_edge_clamped_smoother_core
    import sgsm_pkg::*;
#(
    parameter int MAX_HALF = MAX_HALF_DEF
) (
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  logic                     i_in_valid,
    output logic                     o_in_stall,
    input  t_in_item                 i_in_data,
    output logic                     o_out_valid,
    input  logic                     i_out_stall,
    output t_out_item                o_out_data,
    input  logic                     i_cfg_valid,
    output logic                     o_cfg_ready,
    input  t_cfg_idx                 i_cfg_index,
    input  logic [CFG_DATA_BITS-1:0] i_cfg_data
);

    localparam int WIN   = 2 * MAX_HALF + 1;
    localparam int K_W   = $clog2(WIN);
    localparam int D_W   = $clog2(MAX_HALF + 1);
    localparam int CNT_W = $clog2(WIN + 1);

    t_dp_cmd          cmd;
    logic [D_W-1:0]   d_sel;
    logic [K_W-1:0]   k_sel;
    logic [CNT_W-1:0] seen;
    logic [D_W-1:0]   h_eff;
    logic             out_busy;

    // Configuration registers take a write in any cycle
    assign o_cfg_ready = 1'b1;

    sgsm_ctrl #(
        .MAX_HALF (MAX_HALF)
    ) u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .i_final    (i_in_data.final_sample),
        .i_seen     (seen),
        .i_h        (h_eff),
        .i_busy     (out_busy),
        .o_in_stall (o_in_stall),
        .o_cmd      (cmd),
        .o_d        (d_sel),
        .o_k        (k_sel)
    );

    sgsm_dp #(
        .MAX_HALF (MAX_HALF)
    ) u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_valid (i_cfg_valid && o_cfg_ready),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .i_sample    (i_in_data.sample),
        .i_cmd       (cmd),
        .i_d         (d_sel),
        .i_k         (k_sel),
        .i_out_stall (i_out_stall),
        .o_seen      (seen),
        .o_h         (h_eff),
        .o_busy      (out_busy),
        .o_out_valid (o_out_valid),
        .o_out_data  (o_out_data)
    );

endmodule
